[rtl/assert_macros.svh]
// Assertion macros shared by the spectral multiply-by-x RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true on a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[rtl/smx_pkg.sv]
`timescale 1ns / 1ps
// Package for the spectral multiply-by-x block: fixed widths, register map,
// basis codes and the request type passed from front end to back end. No dependencies.
package smx_pkg;

  // Coefficient word width.
  localparam int COEF_W = 32;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_BASIS_MODE = 1'b0;

  // Basis codes.
  localparam logic BASIS_CHEBYSHEV = 1'b0;
  localparam logic BASIS_LEGENDRE  = 1'b1;

  // Request queue between front end and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // One accepted coefficient turned into at most two results: the middle result
  // of the window and, at the end of a series, the closing result.
  typedef struct packed {
    logic signed [COEF_W-1:0] mid_lo;
    logic signed [COEF_W-1:0] mid_hi;
    logic signed [COEF_W-1:0] end_lo;
    logic                     has_mid;
    logic                     has_end;
  } job_entry_t;

endpackage

[rtl/smx_queue.sv]
`timescale 1ns / 1ps
// Small register FIFO that decouples the front end from the back end.
// Depends on smx_pkg for its depth and on assert_macros.svh for checks.
`include "assert_macros.svh"

module smx_queue
  import smx_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wr_data,
  input  logic         rd,
  output logic [W-1:0] rd_data,
  output logic         empty,
  output logic         full
);

  logic [W-1:0]           mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] head;
  logic [QUEUE_PTR_W-1:0] tail;
  logic [QUEUE_CNT_W-1:0] count;

  assign rd_data = mem[head];
  assign empty   = (count == '0);
  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));

  // Storage is written at the tail without reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[tail] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= tail + 1'b1;
      end
      if (rd) begin
        head <= head + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_queue_overflow, wr && full && !rd, "request queue written while full")
  `ASSERT_NEVER(a_queue_underflow, rd && empty, "request queue read while empty")

endmodule

[rtl/smx_front.sv]
`timescale 1ns / 1ps
// Front end: accepts coefficients, keeps the sliding window and series index,
// and turns each coefficient into a request for the back end. Depends on smx_pkg.
module smx_front
  import smx_pkg::*;
#(
  parameter int MAX_COEFS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            q_full,
  input  logic signed [COEF_W-1:0]        coef_in,
  input  logic                            in_last,
  output logic                            q_wr,
  output job_entry_t                      entry,
  output logic [$clog2(MAX_COEFS)-1:0]    mid_idx,
  output logic [$clog2(MAX_COEFS)-1:0]    end_idx
);

  localparam int IDX_W = $clog2(MAX_COEFS);
  localparam int CNT_W = $clog2(MAX_COEFS + 1);

  logic signed [COEF_W-1:0] prev_coef;
  logic signed [COEF_W-1:0] prev_prev_coef;
  logic [CNT_W-1:0]         coef_index;
  logic [CNT_W-1:0]         coef_index_next;
  logic                     accept;

  assign accept = push && !q_full;

  // Build the request; a missing lower neighbor is forced to zero.
  always_comb begin
    entry.has_mid = (coef_index != '0);
    entry.has_end = in_last;
    entry.mid_lo  = (coef_index >= CNT_W'(2)) ? prev_prev_coef : '0;
    entry.mid_hi  = coef_in;
    entry.end_lo  = (coef_index != '0) ? prev_coef : '0;
    mid_idx       = IDX_W'(coef_index - 1'b1);
    end_idx       = (coef_index >= CNT_W'(MAX_COEFS)) ? IDX_W'(MAX_COEFS - 1)
                                                      : IDX_W'(coef_index);
  end

  // The first coefficient of a longer series produces nothing.
  assign q_wr = accept && (entry.has_mid || entry.has_end);

  // The index saturates on overlong series.
  always_comb begin
    if (in_last) begin
      coef_index_next = '0;
    end else if (coef_index >= CNT_W'(MAX_COEFS)) begin
      coef_index_next = CNT_W'(MAX_COEFS);
    end else begin
      coef_index_next = coef_index + 1'b1;
    end
  end

  // Window and index update; everything clears at the end of a series.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_coef      <= '0;
      prev_prev_coef <= '0;
      coef_index     <= '0;
    end else if (accept) begin
      coef_index <= coef_index_next;
      if (in_last) begin
        prev_coef      <= '0;
        prev_prev_coef <= '0;
      end else begin
        prev_prev_coef <= prev_coef;
        prev_coef      <= coef_in;
      end
    end
  end

endmodule

[rtl/smx_back.sv]
`timescale 1ns / 1ps
// Back end: issues one result per cycle from queued requests unless the output stalls, derives
// the Legendre weights in a pipelined divider, multiplies, rounds and saturates. Uses smx_pkg.
`include "assert_macros.svh"

module smx_back
  import smx_pkg::*;
#(
  parameter int IDX_W     = 10,
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     basis_mode,
  input  logic                     q_empty,
  input  job_entry_t               q_entry,
  input  logic [IDX_W-1:0]         q_mid_idx,
  input  logic [IDX_W-1:0]         q_end_idx,
  output logic                     q_pop,
  input  logic                     pop,
  output logic                     empty,
  output logic signed [COEF_W-1:0] coef_out,
  output logic                     out_last
);

  localparam int S  = FRAC_BITS + 1;           // divider stages, one quotient bit each
  localparam int QW = FRAC_BITS + 1;           // weight width, up to 1.0
  localparam int DW = IDX_W + 2;               // divisor width
  localparam int RW = IDX_W + FRAC_BITS + 3;   // remainder width
  localparam int PW = COEF_W + QW + 1;         // product width
  localparam int SW = PW + 1;                  // sum width
  localparam int TW = SW - FRAC_BITS;          // rounded sum width

  localparam logic [QW-1:0] W_ONE  = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0] W_HALF = QW'(1) << (FRAC_BITS - 1);

  // Issue control.
  logic             phase;
  logic             split;
  logic             take_mid;
  logic             issue;
  logic             advance;
  logic             out_valid;
  logic [IDX_W-1:0] job_idx;
  logic [IDX_W-1:0] lo_idx;

  // Divider pipeline, stage 0 is the issue register.
  logic                     sv     [0:S];
  logic [RW-1:0]            rem_lo [0:S];
  logic [RW-1:0]            rem_hi [0:S];
  logic [DW-1:0]            den_lo [0:S];
  logic [DW-1:0]            den_hi [0:S];
  logic [QW-1:0]            q_lo   [0:S];
  logic [QW-1:0]            q_hi   [0:S];
  logic                     idx_one[0:S];
  logic signed [COEF_W-1:0] op_lo  [0:S];
  logic signed [COEF_W-1:0] op_hi  [0:S];
  logic                     lst    [0:S];

  // Multiply stage.
  logic                 mv;
  logic signed [PW-1:0] m_lo;
  logic signed [PW-1:0] m_hi;
  logic                 m_last;
  logic [QW-1:0]        w_lo;
  logic [QW-1:0]        w_hi;

  // Round and saturate.
  logic signed [SW-1:0] acc;
  logic [TW-1:0]        rnd;
  logic [COEF_W-1:0]    sat;
  logic                 in_range;

  assign advance = !out_valid || pop;
  assign empty   = !out_valid;

  // A closing request with a middle result issues the middle result first, then the closing one.
  assign split    = q_entry.has_mid && q_entry.has_end;
  assign take_mid = !phase && q_entry.has_mid;
  assign issue    = advance && !q_empty;
  assign q_pop    = issue && (!split || phase);
  assign job_idx  = take_mid ? q_mid_idx : q_end_idx;
  // The lower weight at index zero is never used, so index one keeps the divisor sane.
  assign lo_idx   = (job_idx == '0) ? IDX_W'(1) : job_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (issue) begin
      phase <= split && !phase;
    end
  end

  // Stage 0: load dividends with their rounding terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (advance) begin
      sv[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_lo[0]  <= (RW'(lo_idx) << FRAC_BITS) + RW'(lo_idx) - RW'(1);
      den_lo[0]  <= (DW'(lo_idx) << 1) - DW'(1);
      rem_hi[0]  <= ((RW'(job_idx) + RW'(1)) << FRAC_BITS) + RW'(job_idx) + RW'(1);
      den_hi[0]  <= (DW'(job_idx) << 1) + DW'(3);
      q_lo[0]    <= '0;
      q_hi[0]    <= '0;
      idx_one[0] <= (job_idx == IDX_W'(1));
      op_lo[0]   <= take_mid ? q_entry.mid_lo : q_entry.end_lo;
      op_hi[0]   <= take_mid ? q_entry.mid_hi : '0;
      lst[0]     <= !take_mid;
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar s = 1; s <= S; s++) begin : g_div
    localparam int K = FRAC_BITS + 1 - s;
    logic [RW:0] d_lo;
    logic [RW:0] d_hi;

    assign d_lo = {1'b0, rem_lo[s-1]} - {1'b0, RW'(den_lo[s-1]) << K};
    assign d_hi = {1'b0, rem_hi[s-1]} - {1'b0, RW'(den_hi[s-1]) << K};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s] <= 1'b0;
      end else if (advance) begin
        sv[s] <= sv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem_lo[s]  <= d_lo[RW] ? rem_lo[s-1] : d_lo[RW-1:0];
        rem_hi[s]  <= d_hi[RW] ? rem_hi[s-1] : d_hi[RW-1:0];
        q_lo[s]    <= q_lo[s-1] | (QW'(!d_lo[RW]) << K);
        q_hi[s]    <= q_hi[s-1] | (QW'(!d_hi[RW]) << K);
        den_lo[s]  <= den_lo[s-1];
        den_hi[s]  <= den_hi[s-1];
        idx_one[s] <= idx_one[s-1];
        op_lo[s]   <= op_lo[s-1];
        op_hi[s]   <= op_hi[s-1];
        lst[s]     <= lst[s-1];
      end
    end
  end

  // Weight selection by basis.
  always_comb begin
    if (basis_mode == BASIS_LEGENDRE) begin
      w_lo = q_lo[S];
      w_hi = q_hi[S];
    end else begin
      w_lo = idx_one[S] ? W_ONE : W_HALF;
      w_hi = W_HALF;
    end
  end

  // Multiply stage: two independent products.
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (advance) begin
      mv <= sv[S];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_lo   <= op_lo[S] * $signed({1'b0, w_lo});
      m_hi   <= op_hi[S] * $signed({1'b0, w_hi});
      m_last <= lst[S];
    end
  end

  // Round half up, floor by the fraction width, then clamp to 32 bits.
  always_comb begin
    acc      = SW'(m_lo) + SW'(m_hi) + (SW'(1) <<< (FRAC_BITS - 1));
    rnd      = acc[SW-1:FRAC_BITS];
    in_range = (&rnd[TW-1:COEF_W-1]) || !(|rnd[TW-1:COEF_W-1]);
    if (in_range) begin
      sat = rnd[COEF_W-1:0];
    end else if (rnd[TW-1]) begin
      sat = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mv) begin
      coef_out <= sat;
      out_last <= m_last;
    end
  end

  `ASSERT_CLK(a_phase_split, phase |-> (!q_empty && split), "second half issued without a split request")

endmodule

[rtl/spectral_multiply_by_x.sv]
`timescale 1ns / 1ps
// Spectral multiply-by-x: coefficients in, coefficients of x times the series out.
// A request passes the issue register, the divider stages, the multiply and output registers.
// Throughput: one coefficient per cycle while full is low; the back end issues one result per cycle
// unless the output stalls, so a closing coefficient with two results issues them one after the other.
// Reset (synchronous, rst high) clears the window, index, queue and basis_mode.
module spectral_multiply_by_x
  import smx_pkg::*;
#(
  parameter int MAX_COEFS = 1024,
  parameter int FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready,
  // Coefficient input.
  input  logic                     push,
  output logic                     full,
  input  logic signed [COEF_W-1:0] coef_in,
  input  logic                     in_last,
  // Result output.
  output logic                     empty,
  input  logic                     pop,
  output logic signed [COEF_W-1:0] coef_out,
  output logic                     out_last
);

  localparam int IDX_W = $clog2(MAX_COEFS);
  localparam int QW    = $bits(job_entry_t) + 2 * IDX_W;

  logic             basis_mode;
  logic             cfg_write;
  logic             q_wr;
  logic             q_pop;
  logic             q_empty;
  job_entry_t       f_entry;
  job_entry_t       b_entry;
  logic [IDX_W-1:0] f_mid_idx;
  logic [IDX_W-1:0] f_end_idx;
  logic [IDX_W-1:0] b_mid_idx;
  logic [IDX_W-1:0] b_end_idx;
  logic [QW-1:0]    q_rd_data;

  // Register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_mode <= BASIS_CHEBYSHEV;
    end else if (cfg_write && (paddr[CFG_ADDR_W-1:2] == REG_BASIS_MODE)) begin
      basis_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_BASIS_MODE)
                ? {{(CFG_DATA_W-1){1'b0}}, basis_mode} : '0;

  smx_front #(
    .MAX_COEFS(MAX_COEFS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .q_full  (full),
    .coef_in (coef_in),
    .in_last (in_last),
    .q_wr    (q_wr),
    .entry   (f_entry),
    .mid_idx (f_mid_idx),
    .end_idx (f_end_idx)
  );

  smx_queue #(
    .W(QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data ({f_entry, f_mid_idx, f_end_idx}),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .full    (full)
  );

  assign {b_entry, b_mid_idx, b_end_idx} = q_rd_data;

  smx_back #(
    .IDX_W    (IDX_W),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .basis_mode (basis_mode),
    .q_empty    (q_empty),
    .q_entry    (b_entry),
    .q_mid_idx  (b_mid_idx),
    .q_end_idx  (b_end_idx),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .coef_out   (coef_out),
    .out_last   (out_last)
  );

endmodule

[dv/spectral_multiply_by_x_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for spectral_multiply_by_x: streams coefficient series in both bases
// and checks every result coefficient against an in-bench predictor of x times the series.
// Depends on smx_pkg and the spectral_multiply_by_x RTL only.
module spectral_multiply_by_x_test
  import smx_pkg::*;
();

  localparam int MAX_COEFS = 1024;
  localparam int FRAC_BITS = 24;
  localparam int SETTLE_CYCLES = FRAC_BITS + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BASIS_MODE = CFG_ADDR_W'(4 * REG_BASIS_MODE);
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = CFG_ADDR_W'(4);
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic                     last;
  } x_coef_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]    paddr = '0;
  logic [CFG_DATA_W-1:0]    pwdata = '0;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;
  logic                     push = 1'b0;
  logic                     full;
  logic signed [COEF_W-1:0] coef_in = '0;
  logic                     in_last = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [COEF_W-1:0] coef_out;
  logic                     out_last;

  // Predictor state: basis, sliding window and index of the current series.
  logic                     basis_m = BASIS_CHEBYSHEV;
  logic signed [COEF_W-1:0] prev_coef_m = '0;
  logic signed [COEF_W-1:0] prev_prev_coef_m = '0;
  logic [10:0]              coef_index_m = '0;
  x_coef_t                  pending_x_coefs[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int fail_count = 0;
  int coefs_sent = 0;
  int series_sent = 0;
  int legendre_coefs = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  spectral_multiply_by_x #(
    .MAX_COEFS(MAX_COEFS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .full(full),
    .coef_in(coef_in),
    .in_last(in_last),
    .empty(empty),
    .pop(pop),
    .coef_out(coef_out),
    .out_last(out_last)
  );

  // Free-running clock.
  always #1 clk = ~clk;

  // One line per mismatch, and a running count.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  // Weight round(num/den) with FRAC_BITS fractional bits.
  function automatic longint ratio_word(input longint unsigned num, input longint unsigned den);
    return longint'(((num << FRAC_BITS) + den / 2) / den);
  endfunction

  function automatic int unsigned clamp_index(input int unsigned i);
    return (i > MAX_COEFS - 1) ? MAX_COEFS - 1 : i;
  endfunction

  function automatic longint weight_low(input int unsigned i);
    int unsigned k;
    k = clamp_index(i);
    if (k == 0) return 0;
    if (basis_m == BASIS_CHEBYSHEV) begin
      return (k == 1) ? (64'sd1 <<< FRAC_BITS) : (64'sd1 <<< (FRAC_BITS - 1));
    end
    return ratio_word(k, 2 * k - 1);
  endfunction

  function automatic longint weight_high(input int unsigned i);
    int unsigned k;
    k = clamp_index(i);
    if (basis_m == BASIS_CHEBYSHEV) return 64'sd1 <<< (FRAC_BITS - 1);
    return ratio_word(k + 1, 2 * k + 3);
  endfunction

  // Exact weighted sum, rounded half toward plus infinity, then saturated.
  function automatic logic signed [COEF_W-1:0] x_coef(input int unsigned i, input longint lo,
                                                       input longint hi);
    longint acc;
    longint q;
    acc = lo * weight_low(i) + hi * weight_high(i);
    q = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > longint'(COEF_MAX)) q = longint'(COEF_MAX);
    if (q < longint'(COEF_MIN)) q = longint'(COEF_MIN);
    return q[COEF_W-1:0];
  endfunction

  // Advance the predicted window by one accepted coefficient and queue its results.
  task automatic predict_x_coefs(input logic signed [COEF_W-1:0] c, input logic last);
    int unsigned n;
    x_coef_t     r;
    n = 32'(coef_index_m);
    if (n > 0) begin
      r.coef = x_coef(n - 1, (n >= 2) ? longint'(prev_prev_coef_m) : 0, longint'(c));
      r.last = 1'b0;
      pending_x_coefs.push_back(r);
    end
    if (last) begin
      r.coef = x_coef(n, (n >= 1) ? longint'(prev_coef_m) : 0, 0);
      r.last = 1'b1;
      pending_x_coefs.push_back(r);
      prev_coef_m = '0;
      prev_prev_coef_m = '0;
      coef_index_m = '0;
    end else begin
      prev_prev_coef_m = prev_coef_m;
      prev_coef_m = c;
      coef_index_m = (n >= MAX_COEFS) ? 11'(MAX_COEFS) : 11'(n + 1);
    end
  endtask

  // Send one coefficient request, with random idle cycles ahead of it.
  task automatic send_coef(input logic signed [COEF_W-1:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    coef_in <= c;
    in_last <= last;
    do @(posedge clk); while (full);
    predict_x_coefs(c, last);
    coefs_sent++;
    if (basis_m == BASIS_LEGENDRE) legendre_coefs++;
    if (last) series_sent++;
  endtask

  // Stop sending, wait for every expected result and let the pipeline settle.
  task automatic wait_for_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_x_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data,
                              output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write while idle, followed by a readback of basis_mode.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] rd;
    wait_for_idle();
    apb_transfer(1'b1, addr, data, rd);
    if (addr == ADDR_BASIS_MODE) basis_m = data[0];
    reg_writes++;
    apb_transfer(1'b0, ADDR_BASIS_MODE, '0, rd);
    if (rd !== {{(CFG_DATA_W-1){1'b0}}, basis_m}) begin
      report_mismatch("basis_mode readback", rd, {{(CFG_DATA_W-1){1'b0}}, basis_m});
    end
  endtask

  function automatic logic signed [COEF_W-1:0] random_coef();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom();
    if (pick < 70) return COEF_W'($urandom_range(512)) - 32'sd256;
    if (pick < 90) begin
      case ($urandom_range(4))
        0: return COEF_MAX;
        1: return COEF_MIN;
        2: return '0;
        3: return 32'sd1;
        default: return -32'sd1;
      endcase
    end
    if ($urandom_range(1) == 1) return 32'sh4000_0000 + COEF_W'($urandom_range(4095));
    return 32'shC000_0000 - COEF_W'($urandom_range(4095));
  endfunction

  // Mostly short series, some single and pair series, a few long ones.
  function automatic int random_series_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 1;
    if (pick < 20) return 2;
    if (pick < 80) return $urandom_range(8, 3);
    return $urandom_range(60, 9);
  endfunction

  // Basis after reset must be Chebyshev, before any register write.
  task automatic test_reset_default();
    logic [CFG_DATA_W-1:0] rd;
    apb_transfer(1'b0, ADDR_BASIS_MODE, '0, rd);
    if (rd !== {{(CFG_DATA_W-1){1'b0}}, BASIS_CHEBYSHEV}) begin
      report_mismatch("basis_mode after reset", rd, {{(CFG_DATA_W-1){1'b0}}, BASIS_CHEBYSHEV});
    end
    send_coef(32'sh0100_0000, 1'b0);
    send_coef(32'sh0300_0000, 1'b1);
  endtask

  // Single and pair series, saturation both ways and rounding ties in one basis.
  task automatic test_extremes(input logic mode);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    data[0] = mode;
    write_reg(ADDR_BASIS_MODE, data);
    send_coef(COEF_MIN, 1'b1);
    send_coef(COEF_MIN, 1'b0);
    send_coef(COEF_MAX, 1'b1);
    send_coef(COEF_MAX, 1'b0);
    send_coef(COEF_MIN, 1'b0);
    send_coef(COEF_MAX, 1'b0);
    send_coef(32'sd1, 1'b0);
    send_coef(-32'sd1, 1'b1);
    send_coef(COEF_MIN, 1'b0);
    send_coef(32'sd1, 1'b0);
    send_coef(COEF_MIN, 1'b0);
    send_coef(-32'sd1, 1'b1);
  endtask

  // Unmapped writes are ignored and only the low data bit is kept.
  task automatic test_register_map();
    write_reg(ADDR_BASIS_MODE, 32'h0000_0001);
    write_reg(ADDR_UNMAPPED, 32'h0000_0000);
    send_coef(32'sh0080_0000, 1'b0);
    send_coef(-32'sh0123_4567, 1'b0);
    send_coef(32'sh0765_4321, 1'b1);
    write_reg(ADDR_BASIS_MODE, 32'hFFFF_FFFE);
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    send_coef(32'sh0080_0000, 1'b0);
    send_coef(-32'sh0123_4567, 1'b0);
    send_coef(32'sh0765_4321, 1'b1);
  endtask

  // Series longer than MAX_COEFS: index saturates, window keeps sliding.
  task automatic test_overlong_series();
    int k;
    write_reg(ADDR_BASIS_MODE, {{(CFG_DATA_W-1){1'b0}}, BASIS_LEGENDRE});
    for (k = 0; k < MAX_COEFS + 6; k++) send_coef(random_coef(), 1'b0);
    send_coef(random_coef(), 1'b1);
  endtask

  // Random series under one idling pattern and one basis.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input logic mode,
                                     input int n_coefs);
    logic [CFG_DATA_W-1:0] data;
    int sent;
    int len;
    int k;
    data = $urandom();
    data[0] = mode;
    write_reg(ADDR_BASIS_MODE, data);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_coefs) begin
      len = random_series_len();
      for (k = 0; k < len; k++) send_coef(random_coef(), k == len - 1);
      sent += len;
    end
  endtask

  // Result side: random pop stalls, changed on the falling edge.
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin : result_check
    x_coef_t want;
    if (!rst && pop && !empty) begin
      if (pending_x_coefs.size() == 0) begin
        report_mismatch("result with nothing expected", coef_out, '0);
      end else begin
        want = pending_x_coefs.pop_front();
        if (coef_out !== want.coef) report_mismatch("coef_out", coef_out, want.coef);
        if (out_last !== want.last) report_mismatch("out_last", 32'(out_last), 32'(want.last));
        results_checked++;
      end
    end
  end

  // Watchdog: too many cycles with no request accepted on any port.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request accepted for %0d cycles", idle_cycles);
      $display("spectral_multiply_by_x_test NOT OK");
      $finish;
    end else if (rst || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_extremes(BASIS_CHEBYSHEV);
    test_extremes(BASIS_LEGENDRE);
    test_register_map();
    test_overlong_series();
    test_random_traffic(0, 0, BASIS_CHEBYSHEV, 30);
    test_random_traffic(0, 0, BASIS_LEGENDRE, 30);
    test_random_traffic(72, 0, BASIS_LEGENDRE, 30);
    test_random_traffic(72, 0, BASIS_CHEBYSHEV, 30);
    test_random_traffic(0, 72, BASIS_CHEBYSHEV, 30);
    test_random_traffic(0, 72, BASIS_LEGENDRE, 30);
    test_random_traffic(27, 27, BASIS_LEGENDRE, 30);
    test_random_traffic(27, 27, BASIS_CHEBYSHEV, 30);
    wait_for_idle();

    $display("Covered %0d coefficients in %0d series (%0d in Legendre basis), %0d register writes.",
             coefs_sent, series_sent, legendre_coefs, reg_writes);
    $display("Checked %0d result coefficients; %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("spectral_multiply_by_x_test OK");
    end else begin
      $display("spectral_multiply_by_x_test NOT OK");
    end
    $finish;
  end

endmodule
